FILE: hdl/ipa_pkg.sv
// Shared constants and types for the indexed pool allocator.
// No dependencies; every other file of the block imports this package.
package ipa_pkg;

    localparam int CAPACITY = 128;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 8;
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CNT_W-1:0] NIL_LINK = CNT_W'(CAPACITY);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam logic REG_INITIAL = 1'b0;
    localparam logic REG_STEP    = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

FILE: hdl/ipa_link_ram.sv
// Free list link memory: one write port and one read port, registered read.
// Depends on ipa_pkg for the slot and link widths.
module ipa_link_ram
    import ipa_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  logic [CNT_W-1:0]  wdata,
    input  logic [SLOT_W-1:0] raddr,
    output logic [CNT_W-1:0]  rdata
);

    logic [CNT_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/indexed_pool_allocator.sv
// Indexed pool allocator top level: command decode, pool growth and free list control.
// Depends on ipa_pkg and ipa_link_ram.
//
// Usage: a command beat (op, slot_index) is taken at a clock edge where start is
// high and busy is low. The busy flag of the slot and the link of the free list head
// are read from synchronous memories at that edge; in the next cycle busy is high
// while the command is decoded and the memories and counters are updated.
// Each command gives exactly one result beat, shown for one cycle with done high; it is
// registered from the decode cycle. No new command is taken while busy is high, that is
// while a command is decoded; the registered read of the flag and link memories sets this.
// Allocate hands out the most recently released slot first, else the newest slot
// that was never used. Pool growth is one range update, so no slot is walked.
// Configuration: cfg_we, cfg_addr and cfg_data write initial_count (0) or
// step_count (1) at once; write only while no command is in flight.
// Reset: the pool is empty, no slot exists, initial_count is 16 and step_count 8.
// The memories need no clearing; their entries are written before they are read.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
module indexed_pool_allocator
    import ipa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              done,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] granted_index,
    output logic              is_busy,
    output logic [CNT_W-1:0]  busy_total,
    output logic [CNT_W-1:0]  free_total
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    init_reg, step_reg;
    logic [1:0]          op_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]    made_reg, made_next;
    logic [CNT_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]    busy_cnt_reg, busy_cnt_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    fresh_lo_reg, fresh_lo_next;
    logic [CNT_W-1:0]    fresh_cnt_reg, fresh_cnt_next;

    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;
    logic              is_busy_reg, is_busy_next;

    logic              accept;
    logic              exec;
    logic              live;
    logic              in_fresh;
    logic [CNT_W-1:0]  idx_w;
    logic [CNT_W-1:0]  room, room2, n1, n2, grow_n;
    logic [CMP_W-1:0]  room_w, room2_w, init_w, step_w;
    logic [CNT_W-1:0]  fr_lo, fr_cnt, fresh_top;

    logic              ram_we;
    logic [CNT_W-1:0]  ram_rdata;

    logic              flag_mem [CAPACITY];
    logic              flag_rdata;
    logic              flag_we;
    logic [SLOT_W-1:0] flag_waddr;
    logic              flag_wdata;

    ipa_link_ram u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (head_reg),
        .raddr (head_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        flag_rdata <= flag_mem[slot_index];
    end

    assign accept   = start && (state_reg == S_IDLE);
    assign exec     = (state_reg == S_EXEC);
    assign idx_w    = CNT_W'(idx_reg);
    assign in_fresh = (idx_w >= fresh_lo_reg) && (idx_w < fresh_lo_reg + fresh_cnt_reg);
    assign live     = (idx_w < made_reg) && !in_fresh && flag_rdata;
    assign ram_we   = exec && (op_reg == OP_RELEASE) && live;

    // Growth only ever happens with an empty free list.
    always_comb
    begin
        room    = CNT_W'(CAPACITY) - made_reg;
        room_w  = CMP_W'(room);
        init_w  = CMP_W'(init_reg);
        step_w  = CMP_W'(step_reg);
        n1      = '0;
        if (made_reg == '0)
        begin
            n1 = (init_w < room_w) ? CNT_W'(init_w) : room;
        end
        room2   = room - n1;
        room2_w = CMP_W'(room2);
        n2      = '0;
        if ((n1 == '0) && (free_reg == '0))
        begin
            n2 = (step_w < room2_w) ? CNT_W'(step_w) : room2;
        end
        grow_n  = n1 + n2;
        if (grow_n != '0)
        begin
            fr_lo  = made_reg;
            fr_cnt = grow_n;
        end
        else
        begin
            fr_lo  = fresh_lo_reg;
            fr_cnt = fresh_cnt_reg;
        end
        fresh_top = fr_lo + fr_cnt - CNT_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        made_next      = made_reg;
        free_next      = free_reg;
        busy_cnt_next  = busy_cnt_reg;
        head_next      = head_reg;
        fresh_lo_next  = fresh_lo_reg;
        fresh_cnt_next = fresh_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;
        is_busy_next   = is_busy_reg;
        flag_we        = 1'b0;
        flag_waddr     = idx_reg;
        flag_wdata     = 1'b0;
        if (exec)
        begin
            done_next    = 1'b1;
            status_next  = ST_BAD_INDEX;
            granted_next = idx_reg;
            is_busy_next = 1'b0;
            case (op_reg)
                OP_ALLOC:
                begin
                    made_next = made_reg + grow_n;
                    if (head_reg != NIL_LINK)
                    begin
                        head_next     = ram_rdata;
                        granted_next  = head_reg[SLOT_W-1:0];
                        flag_we       = 1'b1;
                        flag_waddr    = head_reg[SLOT_W-1:0];
                        flag_wdata    = 1'b1;
                        free_next     = free_reg - CNT_W'(1);
                        busy_cnt_next = busy_cnt_reg + CNT_W'(1);
                        status_next   = ST_OK;
                    end
                    else if (fr_cnt != '0)
                    begin
                        fresh_lo_next  = fr_lo;
                        fresh_cnt_next = fr_cnt - CNT_W'(1);
                        granted_next   = fresh_top[SLOT_W-1:0];
                        flag_we        = 1'b1;
                        flag_waddr     = fresh_top[SLOT_W-1:0];
                        flag_wdata     = 1'b1;
                        free_next      = free_reg + grow_n - CNT_W'(1);
                        busy_cnt_next  = busy_cnt_reg + CNT_W'(1);
                        status_next    = ST_OK;
                    end
                    else
                    begin
                        granted_next = '0;
                        status_next  = ST_EXHAUSTED;
                    end
                end
                OP_RELEASE:
                begin
                    if (live)
                    begin
                        flag_we       = 1'b1;
                        flag_wdata    = 1'b0;
                        head_next     = idx_w;
                        free_next     = free_reg + CNT_W'(1);
                        busy_cnt_next = busy_cnt_reg - CNT_W'(1);
                        status_next   = ST_OK;
                    end
                end
                OP_LOOKUP:
                begin
                    if (live)
                    begin
                        status_next  = ST_OK;
                        is_busy_next = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_BAD_INDEX;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_reg      <= CFG_W'(16);
            step_reg      <= CFG_W'(8);
            made_reg      <= '0;
            free_reg      <= '0;
            busy_cnt_reg  <= '0;
            head_reg      <= NIL_LINK;
            fresh_lo_reg  <= '0;
            fresh_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            made_reg      <= made_next;
            free_reg      <= free_next;
            busy_cnt_reg  <= busy_cnt_next;
            head_reg      <= head_next;
            fresh_lo_reg  <= fresh_lo_next;
            fresh_cnt_reg <= fresh_cnt_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_INITIAL: init_reg <= cfg_data;
                    REG_STEP:    step_reg <= cfg_data;
                    default:     init_reg <= init_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
        is_busy_reg <= is_busy_next;
        if (accept)
        begin
            op_reg  <= op;
            idx_reg <= slot_index;
        end
    end

    assign busy          = exec;
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign is_busy       = is_busy_reg;
    assign busy_total    = busy_cnt_reg;
    assign free_total    = free_reg;

endmodule

FILE: bench/indexed_pool_allocator_tb.sv
// Self-checking bench for indexed_pool_allocator: a directed table, then random command beats.
// Every result beat is compared with an in-bench pool predictor. Depends on ipa_pkg and the RTL.
module indexed_pool_allocator_tb;
    import ipa_pkg::*;

    localparam int NIL = CAPACITY;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot_index;
    logic              cfg_we;
    logic              cfg_addr;
    logic [CFG_W-1:0]  cfg_data;
    logic              done;
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_index;
    logic              is_busy;
    logic [CNT_W-1:0]  busy_total;
    logic [CNT_W-1:0]  free_total;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted;
        logic              in_use;
        logic [CNT_W-1:0]  busy_n;
        logic [CNT_W-1:0]  free_n;
    } pool_result_t;

    typedef struct {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] idx;
        bit                typed;
        logic [1:0]        want_status;
    } cmd_row_t;

    pool_result_t pending_results[$];
    int           mismatches;

    int  init_cnt;
    int  step_cnt;
    bit  slot_busy[CAPACITY];
    int  nxt[CAPACITY];
    int  prv[CAPACITY];
    int  free_hd;
    int  busy_hd;
    int  made;
    int  free_n;
    int  busy_n;

    indexed_pool_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .slot_index    (slot_index),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .granted_index (granted_index),
        .is_busy       (is_busy),
        .busy_total    (busy_total),
        .free_total    (free_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void pool_clear();
        init_cnt = 16;
        step_cnt = 8;
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_busy[i] = 1'b0;
            nxt[i] = NIL;
            prv[i] = NIL;
        end
        free_hd = NIL;
        busy_hd = NIL;
        made = 0;
        free_n = 0;
        busy_n = 0;
    endfunction

    function automatic void free_push(int s);
        prv[s] = NIL;
        nxt[s] = free_hd;
        if (free_hd < NIL)
            prv[free_hd] = s;
        free_hd = s;
        slot_busy[s] = 1'b0;
        free_n++;
    endfunction

    function automatic void pool_grow(int n);
        int room;
        room = CAPACITY - made;
        if (n > room)
            n = room;
        for (int i = 0; i < n; i++)
            free_push(made + i);
        made += n;
    endfunction

    function automatic pool_result_t pool_apply(logic [1:0] cmd, logic [SLOT_W-1:0] idx);
        pool_result_t r;
        int s;
        int p;
        int n;
        bit live;
        r = '0;
        r.status = ST_BAD_INDEX;
        r.granted = idx;
        live = (int'(idx) < made) && slot_busy[idx];
        if (cmd == OP_ALLOC)
        begin
            if (made == 0)
                pool_grow(init_cnt);
            if (free_n == 0)
                pool_grow(step_cnt);
            if (free_hd >= NIL)
            begin
                r.status = ST_EXHAUSTED;
                r.granted = '0;
            end
            else
            begin
                s = free_hd;
                free_hd = nxt[s];
                if (free_hd < NIL)
                    prv[free_hd] = NIL;
                free_n--;
                prv[s] = NIL;
                nxt[s] = busy_hd;
                if (busy_hd < NIL)
                    prv[busy_hd] = s;
                busy_hd = s;
                slot_busy[s] = 1'b1;
                busy_n++;
                r.status = ST_OK;
                r.granted = SLOT_W'(s);
            end
        end
        else if (cmd == OP_RELEASE)
        begin
            if (live)
            begin
                p = prv[idx];
                n = nxt[idx];
                if (p < NIL)
                    nxt[p] = n;
                else
                    busy_hd = n;
                if (n < NIL)
                    prv[n] = p;
                busy_n--;
                free_push(int'(idx));
                r.status = ST_OK;
            end
        end
        else if (cmd == OP_LOOKUP)
        begin
            if (live)
            begin
                r.status = ST_OK;
                r.in_use = 1'b1;
            end
        end
        r.busy_n = CNT_W'(busy_n);
        r.free_n = CNT_W'(free_n);
        return r;
    endfunction

    // Result beats are taken at the edge that ends their cycle; no stall exists.
    always @(posedge clk)
    begin
        pool_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no command outstanding");
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    mismatches++;
                end
                if (granted_index !== exp_r.granted)
                begin
                    $error("granted_index: expected %0d, got %0d", exp_r.granted,
                           granted_index);
                    mismatches++;
                end
                if (is_busy !== exp_r.in_use)
                begin
                    $error("is_busy: expected %0d, got %0d", exp_r.in_use, is_busy);
                    mismatches++;
                end
                if (busy_total !== exp_r.busy_n)
                begin
                    $error("busy_total: expected %0d, got %0d", exp_r.busy_n, busy_total);
                    mismatches++;
                end
                if (free_total !== exp_r.free_n)
                begin
                    $error("free_total: expected %0d, got %0d", exp_r.free_n, free_total);
                    mismatches++;
                end
            end
        end
    end

    task automatic idle_gap();
        int len;
        if ($urandom_range(0, 2) == 0)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Start stays high after the accepting edge; busy keeps that cycle from taking it again.
    task automatic send_cmd(logic [1:0] cmd, logic [SLOT_W-1:0] idx, bit typed,
                            logic [1:0] want_status);
        pool_result_t r;
        start      <= 1'b1;
        op         <= cmd;
        slot_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = pool_apply(cmd, idx);
        if (typed)
            r.status = want_status;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, int value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_INITIAL)
            init_cnt = value & 8'hff;
        else
            step_cnt = value & 8'hff;
        @(posedge clk);
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 3) == 0)
            return SLOT_W'($urandom);
        if (made == 0)
            return '0;
        return SLOT_W'($urandom_range(0, made - 1));
    endfunction

    cmd_row_t directed [14] = '{
        '{OP_LOOKUP,  7'd0,   1'b1, ST_BAD_INDEX},
        '{OP_RELEASE, 7'd127, 1'b1, ST_BAD_INDEX},
        '{OP_ALLOC,   7'd127, 1'b1, ST_OK},
        '{OP_LOOKUP,  7'd15,  1'b1, ST_OK},
        '{OP_UNUSED,  7'd85,  1'b1, ST_BAD_INDEX},
        '{OP_RELEASE, 7'd15,  1'b1, ST_OK},
        '{OP_RELEASE, 7'd15,  1'b1, ST_BAD_INDEX},
        '{OP_ALLOC,   7'd0,   1'b0, ST_OK},
        '{OP_ALLOC,   7'd42,  1'b0, ST_OK},
        '{OP_RELEASE, 7'd14,  1'b0, ST_OK},
        '{OP_LOOKUP,  7'd14,  1'b1, ST_BAD_INDEX},
        '{OP_LOOKUP,  7'd15,  1'b0, ST_OK},
        '{OP_RELEASE, 7'd100, 1'b1, ST_BAD_INDEX},
        '{OP_LOOKUP,  7'd127, 1'b1, ST_BAD_INDEX}
    };

    initial
    begin
        logic [1:0]   cmd;
        int           pick;
        mismatches = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = '0;
        slot_index = '0;
        cfg_we     = 1'b0;
        cfg_addr   = 1'b0;
        cfg_data   = '0;
        pool_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_cmd(directed[i].cmd, directed[i].idx, directed[i].typed,
                     directed[i].want_status);
        end
        drain();

        // Each phase sets new growth counts and then runs random command beats.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_INITIAL, 0);   write_reg(REG_STEP, 1);   end
                1: begin write_reg(REG_INITIAL, 128); write_reg(REG_STEP, 128); end
                2: begin write_reg(REG_INITIAL, 255); write_reg(REG_STEP, 0);   end
                3: begin write_reg(REG_INITIAL, 1);   write_reg(REG_STEP, 255); end
                default:
                begin
                    write_reg(REG_INITIAL, $urandom_range(0, 255));
                    write_reg(REG_STEP, $urandom_range(0, 255));
                end
            endcase
            for (int n = 0; n < 230; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    cmd = OP_ALLOC;
                else if (pick < 80)
                    cmd = OP_RELEASE;
                else if (pick < 97)
                    cmd = OP_LOOKUP;
                else
                    cmd = OP_UNUSED;
                send_cmd(cmd, (cmd == OP_ALLOC) ? SLOT_W'($urandom) : pick_slot(), 1'b0,
                         ST_OK);
                if (n % 60 < 20)
                    idle_gap();
            end
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
